// ===== rtl/swmmm_pkg.sv =====
// Shared types and constants of the sliding-window min/max/mean unit.
`default_nettype none

package swmmm_pkg;

    localparam int          SAMPLE_W            = 32;
    localparam int          WLEN_W              = 7;
    localparam int          COUNT_OUT_W         = 7;
    localparam int          WINDOW_MAX_DEF      = 64;
    localparam logic [6:0]  WINDOW_LENGTH_RESET = 7'd50;

    // register index, taken from paddr[2]
    localparam logic        REG_WINDOW_LENGTH   = 1'b0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRITE,
        S_SCAN,
        S_DIV_INIT,
        S_DIVIDE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic accept;    // capture sample, trim the window
        logic write;     // store the sample, start the scan
        logic scan;      // walk the held entries
        logic div_init;  // load the divider
        logic div_step;  // one quotient bit
        logic load_out;  // move result to the output register
    } t_dp_cmd;

    typedef struct packed {
        logic scan_done;
        logic div_last;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== rtl/swmmm_ctrl.sv =====
// Sequencer of the sliding-window unit: trim, write, scan, divide, output.
`default_nettype none

module swmmm_ctrl import swmmm_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_WRITE;
            end
            S_WRITE: begin
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_stat.scan_done) n_state = S_DIV_INIT;
            end
            S_DIV_INIT: begin
                n_state = S_DIVIDE;
            end
            S_DIVIDE: begin
                if (i_stat.div_last) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            S_WRITE: begin
                o_cmd.write = 1'b1;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            S_DIV_INIT: begin
                o_cmd.div_init = 1'b1;
            end
            S_DIVIDE: begin
                o_cmd.div_step = 1'b1;
            end
            S_DONE: begin
                o_cmd.load_out = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/swmmm_dp.sv =====
// Datapath: ring store, window trim, min/max/sum scan, serial divider, output register.
`default_nettype none

module swmmm_dp import swmmm_pkg::*; #(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire t_dp_cmd                    i_cmd,
    output t_dp_stat                        o_stat,
    input  wire logic [WLEN_W-1:0]          i_window_length,
    input  wire logic signed [SAMPLE_W-1:0] i_sample,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic [SAMPLE_W-1:0]             o_window_max,
    output logic [SAMPLE_W-1:0]             o_window_min,
    output logic [SAMPLE_W-1:0]             o_window_mean,
    output logic [COUNT_OUT_W-1:0]          o_sample_count
);

    localparam int SLOT_W = $clog2(WINDOW_MAX);
    localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW_MAX);
    localparam int DIV_CW = $clog2(SUM_W);
    localparam int EW     = (CNT_W > WLEN_W) ? CNT_W : WLEN_W;

    logic signed [SAMPLE_W-1:0] mem [WINDOW_MAX];

    logic [SLOT_W-1:0]          r_oldest;
    logic [CNT_W-1:0]           r_held;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic [SLOT_W-1:0]          r_rd_ptr;
    logic [CNT_W-1:0]           r_rd_cnt;
    logic                       r_rd_vld;
    logic signed [SAMPLE_W-1:0] r_mem_q;
    logic                       r_first;
    logic signed [SAMPLE_W-1:0] r_hi;
    logic signed [SAMPLE_W-1:0] r_lo;
    logic signed [SUM_W-1:0]    r_sum;
    logic                       r_neg;
    logic [SUM_W-1:0]           r_quo;
    logic [CNT_W-1:0]           r_rem;
    logic [DIV_CW-1:0]          r_div_cnt;
    logic                       r_out_vld;
    logic [SAMPLE_W-1:0]        r_out_max;
    logic [SAMPLE_W-1:0]        r_out_min;
    logic [SAMPLE_W-1:0]        r_out_mean;
    logic [COUNT_OUT_W-1:0]     r_out_cnt;

    // effective window, clamped to 1..WINDOW_MAX
    logic [EW-1:0]    wl_ext;
    logic [CNT_W-1:0] w_eff;
    logic [CNT_W-1:0] drop;
    logic [SLOT_W:0]  trim_sum;
    logic [SLOT_W:0]  slot_sum;
    logic [SLOT_W-1:0] wr_slot;
    logic             rd_issue;
    logic [SUM_W-1:0] sum_mag;
    logic [CNT_W:0]   rem_sh;
    logic             rem_ge;
    logic [SUM_W-1:0] quo_signed;
    logic [EW-1:0]    held_ext;

    always_comb begin
        wl_ext = EW'(i_window_length);
        if (i_window_length == '0) begin
            w_eff = CNT_W'(1);
        end else if (wl_ext > EW'(WINDOW_MAX)) begin
            w_eff = CNT_W'(WINDOW_MAX);
        end else begin
            w_eff = CNT_W'(wl_ext);
        end
        drop     = r_held - (w_eff - CNT_W'(1));
        trim_sum = {1'b0, r_oldest} + (SLOT_W+1)'(drop);
        slot_sum = {1'b0, r_oldest} + (SLOT_W+1)'(r_held);
        if (slot_sum >= (SLOT_W+1)'(WINDOW_MAX)) begin
            wr_slot = SLOT_W'(slot_sum - (SLOT_W+1)'(WINDOW_MAX));
        end else begin
            wr_slot = SLOT_W'(slot_sum);
        end
        rd_issue   = i_cmd.scan && (r_rd_cnt != r_held);
        sum_mag    = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
        rem_sh     = {r_rem, r_quo[SUM_W-1]};
        rem_ge     = rem_sh >= {1'b0, r_held};
        quo_signed = r_neg ? (~r_quo + SUM_W'(1)) : r_quo;
        held_ext   = EW'(r_held);
    end

    // control state of the window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oldest  <= '0;
            r_held    <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.accept && (r_held >= w_eff)) begin
                if (trim_sum >= (SLOT_W+1)'(WINDOW_MAX)) begin
                    r_oldest <= SLOT_W'(trim_sum - (SLOT_W+1)'(WINDOW_MAX));
                end else begin
                    r_oldest <= SLOT_W'(trim_sum);
                end
                r_held <= w_eff - CNT_W'(1);
            end else if (i_cmd.write) begin
                r_held <= r_held + CNT_W'(1);
            end
            r_rd_vld <= rd_issue;
            if (i_cmd.load_out) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // ring store, one write or one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.write) begin
            mem[wr_slot] <= r_sample;
        end
        if (rd_issue) begin
            r_mem_q <= mem[r_rd_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sample <= i_sample;
        end

        if (i_cmd.write) begin
            r_rd_ptr <= r_oldest;
            r_rd_cnt <= '0;
            r_first  <= 1'b1;
        end else if (rd_issue) begin
            r_rd_ptr <= (r_rd_ptr == SLOT_W'(WINDOW_MAX - 1)) ? '0 : r_rd_ptr + SLOT_W'(1);
            r_rd_cnt <= r_rd_cnt + CNT_W'(1);
        end

        if (r_rd_vld) begin
            r_first <= 1'b0;
            if (r_first) begin
                r_hi  <= r_mem_q;
                r_lo  <= r_mem_q;
                r_sum <= SUM_W'(r_mem_q);
            end else begin
                if (r_mem_q > r_hi) r_hi <= r_mem_q;
                if (r_mem_q < r_lo) r_lo <= r_mem_q;
                r_sum <= r_sum + SUM_W'(r_mem_q);
            end
        end

        // restoring divide of |sum| by the count, one bit a cycle
        if (i_cmd.div_init) begin
            r_neg     <= r_sum[SUM_W-1];
            r_quo     <= sum_mag;
            r_rem     <= '0;
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem     <= rem_ge ? CNT_W'(rem_sh - {1'b0, r_held}) : CNT_W'(rem_sh);
            r_quo     <= {r_quo[SUM_W-2:0], rem_ge};
            r_div_cnt <= r_div_cnt + DIV_CW'(1);
        end

        if (i_cmd.load_out) begin
            r_out_max  <= r_hi;
            r_out_min  <= r_lo;
            r_out_mean <= quo_signed[SAMPLE_W-1:0];
            r_out_cnt  <= held_ext[COUNT_OUT_W-1:0];
        end
    end

    always_comb begin
        o_stat.scan_done = (r_rd_cnt == r_held) && !r_rd_vld;
        o_stat.div_last  = (r_div_cnt == DIV_CW'(SUM_W - 1));
        o_stat.out_free  = !r_out_vld || i_out_ready;
    end

    assign o_out_valid    = r_out_vld;
    assign o_window_max   = r_out_max;
    assign o_window_min   = r_out_min;
    assign o_window_mean  = r_out_mean;
    assign o_sample_count = r_out_cnt;

    a_held_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= CNT_W'(WINDOW_MAX))
        else $error("held count above window maximum");

    a_oldest_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oldest <= SLOT_W'(WINDOW_MAX - 1))
        else $error("oldest slot outside the store");

    a_write_holds_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.write |=> (r_held != '0) && (r_held <= w_eff))
        else $error("held count wrong after write");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (!r_out_vld || i_out_ready))
        else $error("result overwritten before transfer");

endmodule

`default_nettype wire

// ===== rtl/sliding_window_min_max_mean_unit.sv =====
// Top level of the sliding-window min/max/mean unit: APB register, sequencer, datapath.
//
// Input stream s_axis_*: one signed 32-bit latency sample per transfer.
// Output stream m_axis_*: one result per sample: window max, min, mean
// (sum / count truncated toward zero) and the number of samples held.
// APB register window_length (byte address 0) sets how many recent samples
// are kept; zero acts as one, values above WINDOW_MAX as WINDOW_MAX.
// Write it only while no sample is in flight.
// Per sample the unit goes through a trim, a store write, a scan over the
// ring memory (one registered read a cycle), a divider load, the
// bit-serial divider and an output load. One sample is worked on at a
// time; s_axis_tready is high only while the sequencer is idle.
// A finished result sits in the output register; the next sample is taken
// meanwhile and waits at the end of its divide until that result is
// transferred. Reset (synchronous, active low) empties the window and sets
// window_length to 50; the store contents need no clearing.
`default_nettype none

module sliding_window_min_max_mean_unit import swmmm_pkg::*; #(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [31:0]  s_axis_tdata,   // [31:0] sample_delay
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [31:0] window_max, [63:32] window_min, [95:64] window_mean,
    // [102:96] sample_count, [103] zero
    output logic [103:0]      m_axis_tdata,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [WLEN_W-1:0]      r_window_length;
    t_dp_cmd                cmd;
    t_dp_stat               stat;
    logic [SAMPLE_W-1:0]    window_max;
    logic [SAMPLE_W-1:0]    window_min;
    logic [SAMPLE_W-1:0]    window_mean;
    logic [COUNT_OUT_W-1:0] sample_count;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= WINDOW_LENGTH_RESET;
        end else if (psel && penable && pwrite && pready
                     && (paddr[2] == REG_WINDOW_LENGTH)) begin
            r_window_length <= pwdata[WLEN_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_WINDOW_LENGTH) ? {25'd0, r_window_length} : 32'd0;

    swmmm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    swmmm_dp #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_window_length (r_window_length),
        .i_sample        (s_axis_tdata),
        .o_out_valid     (m_axis_tvalid),
        .i_out_ready     (m_axis_tready),
        .o_window_max    (window_max),
        .o_window_min    (window_min),
        .o_window_mean   (window_mean),
        .o_sample_count  (sample_count)
    );

    assign m_axis_tdata = {1'b0, sample_count, window_mean, window_min, window_max};

endmodule

`default_nettype wire
